// ===== sv/stok_pkg.sv =====
`default_nettype none
package stok_pkg;
  localparam int LENGTH_BITS = 16;
  localparam logic [15:0] LEN_CAP = (LENGTH_BITS >= 16) ? 16'hFFFF :
                                    16'((32'd1 << LENGTH_BITS) - 32'd1);

  localparam logic [2:0] M_IDLE     = 3'd0;
  localparam logic [2:0] M_IDENT    = 3'd1;
  localparam logic [2:0] M_NUMFIRST = 3'd2;
  localparam logic [2:0] M_NUMINT   = 3'd3;
  localparam logic [2:0] M_NUMDOT   = 3'd4;
  localparam logic [2:0] M_DOTDOT   = 3'd5;
  localparam logic [2:0] M_FRAC     = 3'd6;
  localparam logic [2:0] M_PUNCT    = 3'd7;

  localparam logic [5:0] K_NEWLINE = 6'd0;
  localparam logic [5:0] K_SPACE   = 6'd1;
  localparam logic [5:0] K_IDENT   = 6'd2;
  localparam logic [5:0] K_BOOL    = 6'd3;
  localparam logic [5:0] K_UINT    = 6'd4;
  localparam logic [5:0] K_BYTE    = 6'd5;
  localparam logic [5:0] K_INT     = 6'd6;
  localparam logic [5:0] K_REAL    = 6'd7;
  localparam logic [5:0] K_PERIOD  = 6'd49;
  localparam logic [5:0] K_NONE    = 6'd63;

  // character class codes from the front end
  localparam logic [2:0] C_NEWLINE = 3'd0;
  localparam logic [2:0] C_SPACE   = 3'd1;
  localparam logic [2:0] C_ALPHA   = 3'd2;
  localparam logic [2:0] C_DIGIT   = 3'd3;
  localparam logic [2:0] C_EXTEND  = 3'd4;
  localparam logic [2:0] C_SINGLE  = 3'd5;
  localparam logic [2:0] C_UNKNOWN = 3'd6;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic [2:0] cls;
    logic [5:0] single;
  } cls_item_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic        status;
    logic [31:0] start;
    logic [15:0] length;
    logic        last;
  } tok_t;

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    k = K_NONE;
    unique case (c)
      8'h3D: k = 6'd8;   8'h2B: k = 6'd10;  8'h2D: k = 6'd13;  8'h2A: k = 6'd16;
      8'h2F: k = 6'd18;  8'h25: k = 6'd20;  8'h26: k = 6'd22;  8'h7C: k = 6'd25;
      8'h5E: k = 6'd28;  8'h3C: k = 6'd30;  8'h3E: k = 6'd35;  8'h21: k = 6'd39;
      8'h7E: k = 6'd41;  8'h40: k = 6'd42;  8'h23: k = 6'd43;  8'h24: k = 6'd44;
      8'h3F: k = 6'd45;  8'h3A: k = 6'd46;  8'h3B: k = 6'd47;  8'h2C: k = 6'd48;
      8'h2E: k = 6'd49;  8'h28: k = 6'd50;  8'h29: k = 6'd51;  8'h5B: k = 6'd52;
      8'h5D: k = 6'd53;  8'h7B: k = 6'd54;  8'h7D: k = 6'd55;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
    logic [5:0] k;
    k = K_NONE;
    if (b == 8'h3D) begin
      unique case (a)
        8'h3D: k = 6'd9;   8'h2B: k = 6'd12;  8'h2D: k = 6'd15;  8'h2A: k = 6'd17;
        8'h2F: k = 6'd19;  8'h25: k = 6'd21;  8'h26: k = 6'd23;  8'h7C: k = 6'd26;
        8'h5E: k = 6'd29;  8'h3C: k = 6'd33;  8'h3E: k = 6'd38;  8'h21: k = 6'd40;
        default: k = K_NONE;
      endcase
    end else if (a == b) begin
      unique case (a)
        8'h2B: k = 6'd11;  8'h2D: k = 6'd14;  8'h26: k = 6'd24;
        8'h7C: k = 6'd27;  8'h3C: k = 6'd31;  8'h3E: k = 6'd36;
        default: k = K_NONE;
      endcase
    end
    return k;
  endfunction

  function automatic logic [2:0] classify(input logic [7:0] c);
    logic [2:0] r;
    if (c == 8'd10) r = C_NEWLINE;
    else if (c == 8'd9 || c == 8'd11 || c == 8'd12 || c == 8'd13 || c == 8'd32) r = C_SPACE;
    else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F)
      r = C_ALPHA;
    else if (c >= 8'h30 && c <= 8'h39) r = C_DIGIT;
    else if (c == 8'h3D || c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F ||
             c == 8'h25 || c == 8'h26 || c == 8'h7C || c == 8'h5E || c == 8'h3C ||
             c == 8'h3E || c == 8'h21) r = C_EXTEND;
    else if (single_kind(c) != K_NONE) r = C_SINGLE;
    else r = C_UNKNOWN;
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== sv/stok_if.sv =====
`default_nettype none
interface stok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_char;
  logic       end_of_input;
  modport source (output valid, output source_char, output end_of_input, input ready);
  modport sink (input valid, input source_char, input end_of_input, output ready);
endinterface

interface stok_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic        status;
  logic [31:0] token_start;
  logic [15:0] token_length;
  logic        last;
  modport source (output valid, output token_kind, output status, output token_start,
                  output token_length, output last, input ready);
  modport sink (input valid, input token_kind, input status, input token_start,
                input token_length, input last, output ready);
endinterface
`default_nettype wire

// ===== sv/stok_front.sv =====
`default_nettype none
// Register the byte with its class; two-entry queue toward the back end.
module stok_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_char,
  input  wire logic                 in_eoi,
  output logic                      q_valid,
  input  wire logic                 q_ready,
  output stok_pkg::cls_item_t       q_item
);
  stok_pkg::cls_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r].ch     <= in_char;
      mem_r[wp_r].eoi    <= in_eoi;
      mem_r[wp_r].cls    <= stok_pkg::classify(in_char);
      mem_r[wp_r].single <= stok_pkg::single_kind(in_char);
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== sv/stok_back.sv =====
`default_nettype none
// Lexer state machine: one byte per cycle unless held by the output buffer;
// up to four tokens go into it and drain one per cycle with out_ready high.
module stok_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  output logic                      q_ready,
  input  wire stok_pkg::cls_item_t  q_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output stok_pkg::tok_t            out_tok
);
  logic [2:0]  mode_r, mode_nxt;
  logic [7:0]  la0_r, la0_nxt, la1_r, la1_nxt;
  logic [1:0]  lac_r, lac_nxt;
  logic [31:0] cur_r, cur_nxt, st_r, st_nxt;
  logic [15:0] run_r, run_nxt;
  logic        halt_r, halt_nxt;

  stok_pkg::tok_t buf_r [4];
  stok_pkg::tok_t em [4];
  logic [2:0] bcnt_r, ecnt;
  logic [1:0] bidx_r;
  logic       take;

  logic [7:0]  c;
  logic [2:0]  cls;
  logic [15:0] run1, run2;
  logic        dig, alnum, bt_do;

  assign q_ready   = (bcnt_r == 3'd0) || (bcnt_r == 3'd1 && out_ready);
  assign take      = q_valid && q_ready;
  assign out_valid = (bcnt_r != 3'd0);
  assign out_tok   = buf_r[bidx_r];

  assign c     = q_item.ch;
  assign cls   = q_item.cls;
  assign dig   = (cls == stok_pkg::C_DIGIT);
  assign alnum = dig || (cls == stok_pkg::C_ALPHA);
  assign run1  = (run_r == stok_pkg::LEN_CAP) ? run_r : run_r + 16'd1;
  assign run2  = (run_r >= stok_pkg::LEN_CAP - 16'd1) ? stok_pkg::LEN_CAP : run_r + 16'd2;

  always_comb begin
    logic [5:0]  pk, tk;
    logic        num_tail;
    logic [31:0] p2, p1;
    mode_nxt = mode_r; la0_nxt = la0_r; la1_nxt = la1_r; lac_nxt = lac_r;
    cur_nxt = cur_r; st_nxt = st_r; run_nxt = run_r; halt_nxt = halt_r;
    ecnt = 3'd0; bt_do = 1'b0; num_tail = 1'b0;
    p2 = cur_r - 32'd2; p1 = cur_r - 32'd1;
    for (int i = 0; i < 4; i++) em[i] = '0;
    pk = stok_pkg::pair_kind(la0_r, c);
    tk = stok_pkg::K_NONE;
    if (la0_r == 8'h3C && la1_r == 8'h3C && c == 8'h3D) tk = 6'd32;
    else if (la0_r == 8'h3C && la1_r == 8'h3D && c == 8'h3E) tk = 6'd34;
    else if (la0_r == 8'h3E && la1_r == 8'h3E && c == 8'h3D) tk = 6'd37;

    if (!halt_r) begin
      unique case (mode_r)
        stok_pkg::M_IDENT: begin
          if (alnum) run_nxt = run1;
          else begin
            em[ecnt[1:0]] = '{stok_pkg::K_IDENT, 1'b0, st_r, run_r, 1'b0};
            ecnt = ecnt + 3'd1; bt_do = 1'b1;
          end
        end
        stok_pkg::M_NUMFIRST, stok_pkg::M_NUMINT: begin
          if (mode_r == stok_pkg::M_NUMFIRST && c == 8'h62) begin
            em[0] = '{stok_pkg::K_BOOL, 1'b0, st_r, 16'd2, 1'b0};
            ecnt = 3'd1; mode_nxt = stok_pkg::M_IDLE;
          end else num_tail = 1'b1;
        end
        stok_pkg::M_NUMDOT: begin
          if (dig) begin run_nxt = run2; mode_nxt = stok_pkg::M_FRAC; end
          else if (c == 8'h2E) mode_nxt = stok_pkg::M_DOTDOT;
          else begin
            em[0] = '{stok_pkg::K_REAL, 1'b0, st_r, run1, 1'b0};
            ecnt = 3'd1; bt_do = 1'b1;
          end
        end
        stok_pkg::M_DOTDOT: begin
          if (c == 8'h2E) begin
            em[0] = '{stok_pkg::K_INT, 1'b0, st_r, run_r, 1'b0};
            em[1] = '{stok_pkg::K_PERIOD, 1'b0, p2, 16'd1, 1'b0};
            ecnt = 3'd2;
          end else begin
            em[0] = '{stok_pkg::K_REAL, 1'b0, st_r, run1, 1'b0};
            ecnt = 3'd1;
          end
          em[ecnt[1:0]] = '{stok_pkg::K_PERIOD, 1'b0, p1, 16'd1, 1'b0};
          ecnt = ecnt + 3'd1; bt_do = 1'b1;
        end
        stok_pkg::M_FRAC: begin
          if (dig) run_nxt = run1;
          else begin
            em[0] = '{stok_pkg::K_REAL, 1'b0, st_r, run_r, 1'b0};
            ecnt = 3'd1; bt_do = 1'b1;
          end
        end
        stok_pkg::M_PUNCT: begin
          if (lac_r <= 2'd1) begin
            if ((la0_r == 8'h3C && (c == 8'h3C || c == 8'h3D)) ||
                (la0_r == 8'h3E && c == 8'h3E)) begin
              la1_nxt = c; lac_nxt = 2'd2;
            end else if (pk != stok_pkg::K_NONE) begin
              em[0] = '{pk, 1'b0, st_r, 16'd2, 1'b0};
              ecnt = 3'd1; mode_nxt = stok_pkg::M_IDLE; lac_nxt = 2'd0;
            end else begin
              em[0] = '{stok_pkg::single_kind(la0_r), 1'b0, st_r, 16'd1, 1'b0};
              ecnt = 3'd1; bt_do = 1'b1;
            end
          end else begin
            if (tk != stok_pkg::K_NONE) begin
              em[0] = '{tk, 1'b0, st_r, 16'd3, 1'b0};
              ecnt = 3'd1; mode_nxt = stok_pkg::M_IDLE; lac_nxt = 2'd0;
            end else begin
              em[0] = '{stok_pkg::pair_kind(la0_r, la1_r), 1'b0, st_r, 16'd2, 1'b0};
              ecnt = 3'd1; bt_do = 1'b1;
            end
          end
        end
        default: bt_do = 1'b1;
      endcase

      if (num_tail) begin
        if (dig) begin run_nxt = run1; mode_nxt = stok_pkg::M_NUMINT; end
        else if (c == 8'h75) begin
          em[0] = '{stok_pkg::K_UINT, 1'b0, st_r, run1, 1'b0};
          ecnt = 3'd1; mode_nxt = stok_pkg::M_IDLE;
        end else if (c == 8'h63) begin
          em[0] = '{stok_pkg::K_BYTE, 1'b0, st_r, run1, 1'b0};
          ecnt = 3'd1; mode_nxt = stok_pkg::M_IDLE;
        end else if (c == 8'h2E) mode_nxt = stok_pkg::M_NUMDOT;
        else begin
          em[0] = '{stok_pkg::K_INT, 1'b0, st_r, run_r, 1'b0};
          ecnt = 3'd1; bt_do = 1'b1;
        end
      end

      // start a new token at this byte
      if (bt_do) begin
        mode_nxt = stok_pkg::M_IDLE; lac_nxt = 2'd0; st_nxt = cur_r; run_nxt = 16'd1;
        unique case (cls)
          stok_pkg::C_NEWLINE: begin
            em[ecnt[1:0]] = '{stok_pkg::K_NEWLINE, 1'b0, cur_r, 16'd1, 1'b0};
            ecnt = ecnt + 3'd1;
          end
          stok_pkg::C_SPACE: begin
            em[ecnt[1:0]] = '{stok_pkg::K_SPACE, 1'b0, cur_r, 16'd1, 1'b0};
            ecnt = ecnt + 3'd1;
          end
          stok_pkg::C_ALPHA: mode_nxt = stok_pkg::M_IDENT;
          stok_pkg::C_DIGIT: mode_nxt = (c == 8'h30 || c == 8'h31) ?
                                        stok_pkg::M_NUMFIRST : stok_pkg::M_NUMINT;
          stok_pkg::C_EXTEND: begin
            la0_nxt = c; lac_nxt = 2'd1; mode_nxt = stok_pkg::M_PUNCT;
          end
          stok_pkg::C_SINGLE: begin
            em[ecnt[1:0]] = '{q_item.single, 1'b0, cur_r, 16'd1, 1'b0};
            ecnt = ecnt + 3'd1;
          end
          default: begin
            em[ecnt[1:0]] = '{stok_pkg::K_NEWLINE, 1'b1, cur_r, 16'd1, 1'b0};
            ecnt = ecnt + 3'd1; halt_nxt = 1'b1;
          end
        endcase
      end

      // flush at end of input, using the state left by this byte
      if (q_item.eoi && !halt_nxt) begin
        unique case (mode_nxt)
          stok_pkg::M_IDENT: begin
            em[ecnt[1:0]] = '{stok_pkg::K_IDENT, 1'b0, st_nxt, run_nxt, 1'b0};
            ecnt = ecnt + 3'd1;
          end
          stok_pkg::M_NUMFIRST, stok_pkg::M_NUMINT: begin
            em[ecnt[1:0]] = '{stok_pkg::K_INT, 1'b0, st_nxt, run_nxt, 1'b0};
            ecnt = ecnt + 3'd1;
          end
          stok_pkg::M_NUMDOT, stok_pkg::M_DOTDOT: begin
            em[ecnt[1:0]] = '{stok_pkg::K_REAL, 1'b0, st_nxt,
                              (run_nxt == stok_pkg::LEN_CAP) ? run_nxt : run_nxt + 16'd1,
                              1'b0};
            ecnt = ecnt + 3'd1;
            if (mode_nxt == stok_pkg::M_DOTDOT) begin
              em[ecnt[1:0]] = '{stok_pkg::K_PERIOD, 1'b0, cur_r, 16'd1, 1'b0};
              ecnt = ecnt + 3'd1;
            end
          end
          stok_pkg::M_FRAC: begin
            em[ecnt[1:0]] = '{stok_pkg::K_REAL, 1'b0, st_nxt, run_nxt, 1'b0};
            ecnt = ecnt + 3'd1;
          end
          stok_pkg::M_PUNCT: begin
            if (lac_nxt <= 2'd1)
              em[ecnt[1:0]] = '{stok_pkg::single_kind(la0_nxt), 1'b0, st_nxt, 16'd1, 1'b0};
            else
              em[ecnt[1:0]] = '{stok_pkg::pair_kind(la0_nxt, la1_nxt), 1'b0, st_nxt,
                                16'd2, 1'b0};
            ecnt = ecnt + 3'd1;
          end
          default: ;
        endcase
      end
      cur_nxt = cur_r + 32'd1;
    end

    if (ecnt != 3'd0) em[ecnt[1:0] - 2'd1].last = 1'b1;

    if (q_item.eoi) begin
      mode_nxt = stok_pkg::M_IDLE; la0_nxt = 8'd0; la1_nxt = 8'd0; lac_nxt = 2'd0;
      cur_nxt = 32'd0; st_nxt = 32'd0; run_nxt = 16'd0; halt_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 4; i++) buf_r[i] <= em[i];
    end
    if (!rst_n) begin
      mode_r <= stok_pkg::M_IDLE; la0_r <= 8'd0; la1_r <= 8'd0; lac_r <= 2'd0;
      cur_r <= 32'd0; st_r <= 32'd0; run_r <= 16'd0; halt_r <= 1'b0;
      bcnt_r <= 3'd0; bidx_r <= 2'd0;
    end else if (take) begin
      mode_r <= mode_nxt; la0_r <= la0_nxt; la1_r <= la1_nxt; lac_r <= lac_nxt;
      cur_r <= cur_nxt; st_r <= st_nxt; run_r <= run_nxt; halt_r <= halt_nxt;
      bcnt_r <= ecnt; bidx_r <= 2'd0;
    end else if (out_valid && out_ready) begin
      bcnt_r <= bcnt_r - 3'd1; bidx_r <= bidx_r + 2'd1;
    end
  end
endmodule
`default_nettype wire

// ===== sv/source_tokenizer.sv =====
`default_nettype none
// source_tokenizer: maximal-munch lexer, one source byte per transfer.
// Input channel (in_): source_char plus end_of_input marking the last byte.
// Output channel (out_): token_kind, status, token_start, token_length, last.
// Each byte yields zero to four tokens; last marks the final token of a byte.
// A front stage registers and classifies each byte into a two-entry queue;
// the back end runs the lexer state machine on one byte per cycle and loads
// the tokens that byte produces into a four-entry output buffer.
// The back end takes one byte per cycle while each byte yields at most one
// token and the receiver does not stall; a byte yielding more than one token
// holds it until the single output port has drained all but the last one.
// A transferred byte is written into the front queue, then taken by the back
// end, which loads its tokens into the output buffer that presents them.
// An unknown byte yields an error token (status 1) and later bytes are dropped
// through end_of_input; end_of_input flushes if not halted and zeroes offsets.
// Reset (rst_n low, synchronous) empties queue and buffer and clears state.
// When the receiver stalls, the buffer holds, the queue fills, in_ready drops.
module source_tokenizer (
  input wire logic    clk,
  input wire logic    rst_n,
  stok_in_if.sink     in_ch,
  stok_out_if.source  out_ch
);
  logic                q_valid, q_ready;
  stok_pkg::cls_item_t q_item;
  stok_pkg::tok_t      tok;

  stok_front u_front (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .in_char  (in_ch.source_char), .in_eoi (in_ch.end_of_input),
    .q_valid, .q_ready, .q_item
  );

  stok_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .out_valid (out_ch.valid), .out_ready (out_ch.ready), .out_tok (tok)
  );

  assign out_ch.token_kind   = tok.kind;
  assign out_ch.status       = tok.status;
  assign out_ch.token_start  = tok.start;
  assign out_ch.token_length = tok.length;
  assign out_ch.last         = tok.last;
endmodule
`default_nettype wire

// ===== dv/tb_tok_checker.sv =====
`timescale 1ns / 1ps
module tb_tok_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        in_eoi,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [5:0]  out_kind,
  input  logic        out_status,
  input  logic [31:0] out_start,
  input  logic [15:0] out_length,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_tokens
);
  stok_pkg::tok_t expected_tokens[$];

  logic [7:0]  la_first;
  logic [7:0]  la_second;
  logic [1:0]  la_count;
  logic [2:0]  mode;
  logic [31:0] cur_off;
  logic [31:0] tok_start;
  logic [15:0] run_len;
  logic        halted;
  stok_pkg::tok_t step_toks[$];

  assign pending_tokens = expected_tokens.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic logic [15:0] len_add(input logic [15:0] v, input int d);
    logic [16:0] s;
    s = {1'b0, v} + 17'(d);
    return (s > 17'(stok_pkg::LEN_CAP)) ? stok_pkg::LEN_CAP : s[15:0];
  endfunction

  function automatic bit digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit extendable(input logic [7:0] c);
    return c == "=" || c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
           c == "&" || c == "|" || c == "^" || c == "<" || c == ">" || c == "!";
  endfunction

  function automatic logic [5:0] one_kind(input logic [7:0] c);
    case (c)
      "=": return 6'd8;   "+": return 6'd10;  "-": return 6'd13;  "*": return 6'd16;
      "/": return 6'd18;  "%": return 6'd20;  "&": return 6'd22;  "|": return 6'd25;
      "^": return 6'd28;  "<": return 6'd30;  ">": return 6'd35;  "!": return 6'd39;
      "~": return 6'd41;  "@": return 6'd42;  "#": return 6'd43;  "$": return 6'd44;
      "?": return 6'd45;  ":": return 6'd46;  ";": return 6'd47;  ",": return 6'd48;
      ".": return 6'd49;  "(": return 6'd50;  ")": return 6'd51;  "[": return 6'd52;
      "]": return 6'd53;  "{": return 6'd54;  "}": return 6'd55;
      default: return stok_pkg::K_NONE;
    endcase
  endfunction

  function automatic logic [5:0] two_kind(input logic [7:0] a, input logic [7:0] b);
    if (b == "=") begin
      case (a)
        "=": return 6'd9;   "+": return 6'd12;  "-": return 6'd15;  "*": return 6'd17;
        "/": return 6'd19;  "%": return 6'd21;  "&": return 6'd23;  "|": return 6'd26;
        "^": return 6'd29;  "<": return 6'd33;  ">": return 6'd38;  "!": return 6'd40;
        default: return stok_pkg::K_NONE;
      endcase
    end
    if (a == b) begin
      case (a)
        "+": return 6'd11;  "-": return 6'd14;  "&": return 6'd24;
        "|": return 6'd27;  "<": return 6'd31;  ">": return 6'd36;
        default: return stok_pkg::K_NONE;
      endcase
    end
    return stok_pkg::K_NONE;
  endfunction

  function automatic logic [5:0] three_kind(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    if (a == "<" && b == "<" && c == "=") return 6'd32;
    if (a == "<" && b == "=" && c == ">") return 6'd34;
    if (a == ">" && b == ">" && c == "=") return 6'd37;
    return stok_pkg::K_NONE;
  endfunction

  task automatic push_tok(input logic [5:0] k, input logic st, input logic [31:0] s,
                          input logic [15:0] l);
    stok_pkg::tok_t t;
    t.kind = k;
    t.status = st;
    t.start = s;
    t.length = l;
    t.last = 1'b0;
    if (step_toks.size() < 4) step_toks.insert(step_toks.size(), t);
  endtask

  task automatic open_token(input logic [7:0] c);
    mode = stok_pkg::M_IDLE;
    la_count = 0;
    tok_start = cur_off;
    run_len = 1;
    if (c == 8'd10) push_tok(stok_pkg::K_NEWLINE, 0, cur_off, 1);
    else if (c == 9 || c == 11 || c == 12 || c == 13 || c == 32)
      push_tok(stok_pkg::K_SPACE, 0, cur_off, 1);
    else if (alpha(c)) mode = stok_pkg::M_IDENT;
    else if (digit(c))
      mode = (c == "0" || c == "1") ? stok_pkg::M_NUMFIRST : stok_pkg::M_NUMINT;
    else if (extendable(c)) begin
      la_first = c;
      la_count = 1;
      mode = stok_pkg::M_PUNCT;
    end else if (one_kind(c) != stok_pkg::K_NONE) push_tok(one_kind(c), 0, cur_off, 1);
    else begin
      push_tok(stok_pkg::K_NEWLINE, 1, cur_off, 1);
      halted = 1;
    end
  endtask

  task automatic number_next(input logic [7:0] c);
    if (digit(c)) begin
      run_len = len_add(run_len, 1);
      mode = stok_pkg::M_NUMINT;
    end else if (c == "u") begin
      push_tok(stok_pkg::K_UINT, 0, tok_start, len_add(run_len, 1));
      mode = stok_pkg::M_IDLE;
    end else if (c == "c") begin
      push_tok(stok_pkg::K_BYTE, 0, tok_start, len_add(run_len, 1));
      mode = stok_pkg::M_IDLE;
    end else if (c == ".") mode = stok_pkg::M_NUMDOT;
    else begin
      push_tok(stok_pkg::K_INT, 0, tok_start, run_len);
      open_token(c);
    end
  endtask

  task automatic lex_byte(input logic [7:0] c);
    case (mode)
      stok_pkg::M_IDENT: begin
        if (alpha(c) || digit(c)) run_len = len_add(run_len, 1);
        else begin
          push_tok(stok_pkg::K_IDENT, 0, tok_start, run_len);
          open_token(c);
        end
      end
      stok_pkg::M_NUMFIRST: begin
        if (c == "b") begin
          push_tok(stok_pkg::K_BOOL, 0, tok_start, 2);
          mode = stok_pkg::M_IDLE;
        end else number_next(c);
      end
      stok_pkg::M_NUMINT: number_next(c);
      stok_pkg::M_NUMDOT: begin
        if (digit(c)) begin
          run_len = len_add(run_len, 2);
          mode = stok_pkg::M_FRAC;
        end else if (c == ".") mode = stok_pkg::M_DOTDOT;
        else begin
          push_tok(stok_pkg::K_REAL, 0, tok_start, len_add(run_len, 1));
          open_token(c);
        end
      end
      stok_pkg::M_DOTDOT: begin
        // a third dot splits off the integer; otherwise "N." is real
        if (c == ".") begin
          push_tok(stok_pkg::K_INT, 0, tok_start, run_len);
          push_tok(stok_pkg::K_PERIOD, 0, cur_off - 2, 1);
        end else push_tok(stok_pkg::K_REAL, 0, tok_start, len_add(run_len, 1));
        push_tok(stok_pkg::K_PERIOD, 0, cur_off - 1, 1);
        open_token(c);
      end
      stok_pkg::M_FRAC: begin
        if (digit(c)) run_len = len_add(run_len, 1);
        else begin
          push_tok(stok_pkg::K_REAL, 0, tok_start, run_len);
          open_token(c);
        end
      end
      stok_pkg::M_PUNCT: begin
        if (la_count <= 1) begin
          if ((la_first == "<" && (c == "<" || c == "=")) || (la_first == ">" && c == ">"))
          begin
            la_second = c;
            la_count = 2;
          end else if (two_kind(la_first, c) != stok_pkg::K_NONE) begin
            push_tok(two_kind(la_first, c), 0, tok_start, 2);
            mode = stok_pkg::M_IDLE;
            la_count = 0;
          end else begin
            push_tok(one_kind(la_first), 0, tok_start, 1);
            open_token(c);
          end
        end else if (three_kind(la_first, la_second, c) != stok_pkg::K_NONE) begin
          push_tok(three_kind(la_first, la_second, c), 0, tok_start, 3);
          mode = stok_pkg::M_IDLE;
          la_count = 0;
        end else begin
          push_tok(two_kind(la_first, la_second), 0, tok_start, 2);
          open_token(c);
        end
      end
      default: open_token(c);
    endcase
  endtask

  task automatic flush_pending();
    case (mode)
      stok_pkg::M_IDENT: push_tok(stok_pkg::K_IDENT, 0, tok_start, run_len);
      stok_pkg::M_NUMFIRST, stok_pkg::M_NUMINT:
        push_tok(stok_pkg::K_INT, 0, tok_start, run_len);
      stok_pkg::M_NUMDOT: push_tok(stok_pkg::K_REAL, 0, tok_start, len_add(run_len, 1));
      stok_pkg::M_DOTDOT: begin
        push_tok(stok_pkg::K_REAL, 0, tok_start, len_add(run_len, 1));
        push_tok(stok_pkg::K_PERIOD, 0, cur_off, 1);
      end
      stok_pkg::M_FRAC: push_tok(stok_pkg::K_REAL, 0, tok_start, run_len);
      stok_pkg::M_PUNCT: begin
        if (la_count <= 1) push_tok(one_kind(la_first), 0, tok_start, 1);
        else push_tok(two_kind(la_first, la_second), 0, tok_start, 2);
      end
      default: ;
    endcase
  endtask

  task automatic clear_lexer();
    la_first = 0;
    la_second = 0;
    la_count = 0;
    mode = stok_pkg::M_IDLE;
    cur_off = 0;
    tok_start = 0;
    run_len = 0;
    halted = 0;
  endtask

  task automatic predict_byte(input logic [7:0] c, input logic eoi);
    step_toks.delete();
    if (!halted) begin
      lex_byte(c);
      if (eoi && !halted) flush_pending();
      cur_off++;
    end
    if (eoi) clear_lexer();
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) expected_tokens.insert(expected_tokens.size(), step_toks[i]);
  endtask

  initial begin
    fail_count = 0;
    clear_lexer();
  end

  always @(posedge clk) begin
    stok_pkg::tok_t want;
    if (!rst_n) begin
      clear_lexer();
      expected_tokens.delete();
    end else begin
      if (in_valid && in_ready) predict_byte(in_char, in_eoi);
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) report("unexpected token", out_kind, 0);
        else begin
          want = expected_tokens.pop_front();
          if (out_kind !== want.kind) report("token_kind", out_kind, want.kind);
          if (out_status !== want.status) report("status", out_status, want.status);
          if (out_start !== want.start) report("token_start", out_start, want.start);
          if (out_length !== want.length) report("token_length", out_length, want.length);
          if (out_last !== want.last) report("last", out_last, want.last);
        end
      end
    end
  end
endmodule

// ===== dv/tb_source_tokenizer.sv =====
`timescale 1ns / 1ps
module tb_source_tokenizer;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_tokens;
  int   bytes_sent;
  bit   calm;        // no idling in the last part of the run
  int   send_gap;
  int   recv_stall;

  stok_in_if  in_ch();
  stok_out_if out_ch();

  always #4 clk = ~clk;

  source_tokenizer dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source));

  tb_tok_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_char(in_ch.source_char), .in_eoi(in_ch.end_of_input),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_kind(out_ch.token_kind), .out_status(out_ch.status),
    .out_start(out_ch.token_start), .out_length(out_ch.token_length),
    .out_last(out_ch.last),
    .fail_count(fail_count), .pending_tokens(pending_tokens)
  );

  // Drive one byte and hold it until the transfer; random gaps come first.
  task automatic send_byte(input logic [7:0] c, input logic eoi);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.source_char <= c;
    in_ch.end_of_input <= eoi;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit eoi);
    foreach (s[i]) send_byte(s[i], eoi && i == s.len() - 1);
  endtask

  // Pick a byte biased toward well-formed tokens.
  function automatic logic [7:0] pick_byte();
    string pool;
    pool = "abzAZ_09135.......<<<=>>>=+-&|!*/%^~@#$?:;,()[]{} \n\tucb";
    case ($urandom_range(0, 19))
      0: return 8'($urandom_range(0, 255));
      1: return 8'($urandom_range(128, 255));
      default: return pool[$urandom_range(0, pool.len() - 1)];
    endcase
  endfunction

  // Receiver: stall in short random bursts, never during the calm tail.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall <= 0;
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      out_ch.ready <= (recv_stall == 1);
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      recv_stall <= $urandom_range(1, 3);
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= 1'b1;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.source_char = 8'd0;
    in_ch.end_of_input = 1'b0;
    bytes_sent = 0;
    calm = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: number forms, dots, three-byte punctuators, end flush.
    send_text("0b 1b 12u 7c 3.25 9...", 0);
    send_text("5..x <=><<=>>=<=<<>>", 0);
    send_text("&&||!=-- ++ ~ 0", 1);
    send_text("abc`zz", 0);       // unknown byte halts until end of input
    send_text("q 4.", 1);
    send_text("_Zz9\x0b\x0c\x0d\x7f", 1);
    send_text("8..", 1);
    send_text("ab \xff\x00", 1);
    send_byte(8'h00, 1'b1);

    // Random streams, each closed by an end-of-input byte.
    while (bytes_sent < 245) begin
      if (bytes_sent > 200) calm = 1;
      repeat ($urandom_range(3, 30)) send_byte(pick_byte(), 1'b0);
      send_byte(pick_byte(), 1'b1);
    end
    in_ch.valid <= 1'b0;

    while (pending_tokens > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("source_tokenizer test passed");
    else $display("source_tokenizer test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("source_tokenizer test failed");
    $finish;
  end
endmodule
